// ----- design/bcs_pkg.sv -----
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared widths, register map and types of the boost converter step model.
// ----------------------------------------------------------------------------
package bcs_pkg;

   // State and field widths
   localparam int STATE_WIDTH = 31;
   localparam int PHASE_WIDTH = 16;
   localparam int VIN_WIDTH   = 31;
   localparam int COEF_WIDTH  = 32;
   localparam int COEF_FRAC   = 24;
   localparam int TICK_WIDTH  = 16;
   localparam int INIT_WIDTH  = 31;
   localparam int OUT_WIDTH   = 31;

   // Magnitude of the inductor drive term and the working width of the sums
   localparam int DRV_WIDTH = (VIN_WIDTH > STATE_WIDTH) ? VIN_WIDTH : STATE_WIDTH;
   localparam int ACC_WIDTH = DRV_WIDTH + COEF_WIDTH - COEF_FRAC + 1;
   localparam int CMP_WIDTH = (PHASE_WIDTH > TICK_WIDTH) ? PHASE_WIDTH : TICK_WIDTH;

   localparam logic [ACC_WIDTH-1:0] STATE_MAX =
      {{(ACC_WIDTH-STATE_WIDTH){1'b0}}, {STATE_WIDTH{1'b1}}};

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [TICK_WIDTH-1:0] PERIOD_RESET = 16'd1000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_VIN             = 3'd0,
      CSR_STEP_PER_L      = 3'd1,
      CSR_STEP_PER_C      = 3'd2,
      CSR_STEP_PER_RC     = 3'd3,
      CSR_PERIOD_TICKS    = 3'd4,
      CSR_ON_TICKS        = 3'd5,
      CSR_INITIAL_CURRENT = 3'd6,
      CSR_INITIAL_VOLTAGE = 3'd7
   } bcs_csr_type;

   typedef struct packed {
      logic [VIN_WIDTH-1:0]  vin;
      logic [COEF_WIDTH-1:0] step_per_l;
      logic [COEF_WIDTH-1:0] step_per_c;
      logic [COEF_WIDTH-1:0] step_per_rc;
      logic [TICK_WIDTH-1:0] period_ticks;
      logic [TICK_WIDTH-1:0] on_ticks;
      logic [INIT_WIDTH-1:0] initial_current;
      logic [INIT_WIDTH-1:0] initial_voltage;
   } bcs_cfg_type;

   typedef struct packed {
      logic [OUT_WIDTH-1:0] inductor_current;
      logic [OUT_WIDTH-1:0] capacitor_voltage;
      logic                 switch_on;
   } bcs_result_type;

   // Clamp a working-width value to the state maximum
   function automatic logic [STATE_WIDTH-1:0] sat_state(input logic [ACC_WIDTH-1:0] x);
      logic [ACC_WIDTH-1:0] y;
      y = (x > STATE_MAX) ? STATE_MAX : x;
      return y[STATE_WIDTH-1:0];
   endfunction

endpackage

// ----- design/bcs_req_if.sv -----
// ----------------------------------------------------------------------------
// bcs_req_if
// Step request channel: valid/ready handshake with the restart flag.
// ----------------------------------------------------------------------------
interface bcs_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

// ----- design/bcs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// bcs_rsp_if
// Step response channel: valid/ready handshake with the converter state.
// ----------------------------------------------------------------------------
interface bcs_rsp_if import bcs_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [OUT_WIDTH-1:0] inductor_current;
   logic [OUT_WIDTH-1:0] capacitor_voltage;
   logic                 switch_on;

   modport source (output valid, output inductor_current, output capacitor_voltage,
                   output switch_on, input ready);
   modport sink   (input valid, input inductor_current, input capacitor_voltage,
                   input switch_on, output ready);
endinterface

// ----- design/boost_converter_step_model.sv -----
// ----------------------------------------------------------------------------
// boost_converter_step_model
// Real-time forward-Euler boost converter model, one time step per transfer.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   req_chan  in         valid/ready          restart
//   rsp_chan  out        valid/ready          inductor_current, capacitor_voltage,
//                                             switch_on
//   csr_*     in         csr_we, no ready     csr_index, csr_wdata
//
// One step per clock while req_chan.ready is high: the state update (three parallel 31x32 products, then
// add, compare and clamp) is combinational between the state registers.
// A result is registered into the output entry, or into the skid entry while the output stalls.
// Reset loads the register defaults, clears the state and phase, and empties
// the response buffer; requests are taken from the first cycle after reset.
// A two-entry response buffer takes one more request while the output is stalled;
// req_chan.ready drops only while both entries hold results.
// ----------------------------------------------------------------------------
module boost_converter_step_model import bcs_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   bcs_req_if.sink                    req_chan,
   bcs_rsp_if.source                  rsp_chan,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   bcs_cfg_type    cfg_ff;
   bcs_result_type step_result;

   bcs_result_type out_data_ff, out_data_in;
   bcs_result_type skid_data_ff, skid_data_in;
   logic           out_valid_ff, out_valid_in;
   logic           skid_valid_ff, skid_valid_in;

   logic in_xfer, out_xfer;

   // ---------------------------------------------------------------------
   // Configuration registers: write-only, taken on csr_we
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{period_ticks: PERIOD_RESET, default: '0};
      end else if (csr_we) begin
         unique case (bcs_csr_type'(csr_index))
            CSR_VIN:             cfg_ff.vin             <= csr_wdata[VIN_WIDTH-1:0];
            CSR_STEP_PER_L:      cfg_ff.step_per_l      <= csr_wdata[COEF_WIDTH-1:0];
            CSR_STEP_PER_C:      cfg_ff.step_per_c      <= csr_wdata[COEF_WIDTH-1:0];
            CSR_STEP_PER_RC:     cfg_ff.step_per_rc     <= csr_wdata[COEF_WIDTH-1:0];
            CSR_PERIOD_TICKS:    cfg_ff.period_ticks    <= csr_wdata[TICK_WIDTH-1:0];
            CSR_ON_TICKS:        cfg_ff.on_ticks        <= csr_wdata[TICK_WIDTH-1:0];
            CSR_INITIAL_CURRENT: cfg_ff.initial_current <= csr_wdata[INIT_WIDTH-1:0];
            CSR_INITIAL_VOLTAGE: cfg_ff.initial_voltage <= csr_wdata[INIT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshakes: accept while the skid entry is free
   // ---------------------------------------------------------------------
   assign req_chan.ready = !skid_valid_ff;
   assign in_xfer        = req_chan.valid && !skid_valid_ff;
   assign out_xfer       = out_valid_ff && rsp_chan.ready;

   // ---------------------------------------------------------------------
   // Time step: advance the converter state on every request transfer
   // ---------------------------------------------------------------------
   bcs_step u_step (
      .clock   (clock),
      .reset   (reset),
      .advance (in_xfer),
      .restart (req_chan.restart),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   // ---------------------------------------------------------------------
   // Response buffer: output entry plus one skid entry, kept in order
   // ---------------------------------------------------------------------
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_xfer) begin
         if (skid_valid_ff) begin
            // Promote the waiting result; the skid entry was full, so no new one
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_xfer;
            out_data_in  = step_result;
         end
      end else if (in_xfer) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = step_result;
         end else begin
            // Output stalled: park the new result
            skid_valid_in = 1'b1;
            skid_data_in  = step_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.inductor_current  = out_data_ff.inductor_current;
   assign rsp_chan.capacitor_voltage = out_data_ff.capacitor_voltage;
   assign rsp_chan.switch_on         = out_data_ff.switch_on;

endmodule

// ----- design/bcs_step.sv -----
// ----------------------------------------------------------------------------
// bcs_step
// Converter state registers and the forward-Euler update of one time step.
// ----------------------------------------------------------------------------
module bcs_step import bcs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           restart,
   input  bcs_cfg_type    cfg,
   output bcs_result_type result
);

   localparam int PROD_L_WIDTH = DRV_WIDTH + COEF_WIDTH;
   localparam int PROD_S_WIDTH = STATE_WIDTH + COEF_WIDTH;

   logic [STATE_WIDTH-1:0] current_ff, current_in;
   logic [STATE_WIDTH-1:0] voltage_ff, voltage_in;
   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;

   logic [STATE_WIDTH-1:0]  i0, v0;
   logic [PHASE_WIDTH-1:0]  ph0, ph_inc;
   logic [ACC_WIDTH-1:0]    i0_x, v0_x, vin_x;
   logic                    on, drive_neg;
   logic [DRV_WIDTH-1:0]    drive_mag;
   logic [PROD_L_WIDTH-1:0] prod_l;
   logic [PROD_S_WIDTH-1:0] prod_c, prod_rc;
   logic [ACC_WIDTH-1:0]    term_l, term_c, loss, v_sum;
   logic [ACC_WIDTH-1:0]    ni_x, nv_x;

   // Restart reloads the initial values before the step
   always_comb begin
      if (restart) begin
         i0  = sat_state(ACC_WIDTH'(cfg.initial_current));
         v0  = sat_state(ACC_WIDTH'(cfg.initial_voltage));
         ph0 = '0;
      end else begin
         i0  = current_ff;
         v0  = voltage_ff;
         ph0 = phase_ff;
      end
   end

   assign i0_x  = ACC_WIDTH'(i0);
   assign v0_x  = ACC_WIDTH'(v0);
   assign vin_x = ACC_WIDTH'(cfg.vin);

   assign on        = CMP_WIDTH'(ph0) < CMP_WIDTH'(cfg.on_ticks);
   assign drive_neg = !on && (vin_x < v0_x);

   // Shared inductor drive magnitude: vin when on, |vin - v| when off
   always_comb begin
      if (on) begin
         drive_mag = DRV_WIDTH'(cfg.vin);
      end else if (drive_neg) begin
         drive_mag = DRV_WIDTH'(v0_x - vin_x);
      end else begin
         drive_mag = DRV_WIDTH'(vin_x - v0_x);
      end
   end

   assign prod_l  = PROD_L_WIDTH'(drive_mag) * PROD_L_WIDTH'(cfg.step_per_l);
   assign prod_c  = PROD_S_WIDTH'(i0) * PROD_S_WIDTH'(cfg.step_per_c);
   assign prod_rc = PROD_S_WIDTH'(v0) * PROD_S_WIDTH'(cfg.step_per_rc);

   // Drop the coefficient fraction, truncating toward zero
   assign term_l = ACC_WIDTH'(prod_l[PROD_L_WIDTH-1:COEF_FRAC]);
   assign term_c = ACC_WIDTH'(prod_c[PROD_S_WIDTH-1:COEF_FRAC]);
   assign loss   = ACC_WIDTH'(prod_rc[PROD_S_WIDTH-1:COEF_FRAC]);
   assign v_sum  = v0_x + term_c;

   always_comb begin
      if (drive_neg) begin
         ni_x = (i0_x >= term_l) ? (i0_x - term_l) : '0;
      end else begin
         ni_x = i0_x + term_l;
      end
      if (on) begin
         nv_x = (v0_x >= loss) ? (v0_x - loss) : '0;
      end else begin
         nv_x = (v_sum >= loss) ? (v_sum - loss) : '0;
      end
   end

   assign ph_inc = ph0 + {{(PHASE_WIDTH-1){1'b0}}, 1'b1};

   always_comb begin
      current_in = sat_state(ni_x);
      voltage_in = sat_state(nv_x);
      phase_in   = (CMP_WIDTH'(ph_inc) >= CMP_WIDTH'(cfg.period_ticks)) ? '0 : ph_inc;
   end

   // State and phase registers reset to zero and load only on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         current_ff <= '0;
         voltage_ff <= '0;
         phase_ff   <= '0;
      end else if (advance) begin
         current_ff <= current_in;
         voltage_ff <= voltage_in;
         phase_ff   <= phase_in;
      end
   end

   assign result.inductor_current  = OUT_WIDTH'(current_in);
   assign result.capacitor_voltage = OUT_WIDTH'(voltage_in);
   assign result.switch_on         = on;

endmodule

// ----- tb/sv/boost_converter_step_model_tb.sv -----
// ----------------------------------------------------------------------------
// boost_converter_step_model_tb
// Self-checking bench for the boost converter step model. A tracker class
// keeps its own copy of the registers, the inductor current, the capacitor
// voltage and the PWM phase. For every request transfer it predicts the
// response, and every response transfer is checked against the oldest
// prediction. Directed steps cover zero and saturated state, negative drive,
// zero and lowered periods and always-on duty. Random phases follow, each
// with a fresh register setting, restarts and random gaps on both channels.
// ----------------------------------------------------------------------------
module boost_converter_step_model_tb import bcs_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_STEPS = 1850;
   localparam int CYCLE_LIMIT  = 400_000;

   // -------------------------------------------------------------------------
   // Tracker: register copy, converter state and queue of predicted responses
   // -------------------------------------------------------------------------
   class converter_tracker;
      bcs_cfg_type            cfg;
      logic [STATE_WIDTH-1:0] current_q;
      logic [STATE_WIDTH-1:0] voltage_q;
      logic [PHASE_WIDTH-1:0] phase_q;
      bcs_result_type         expected_states[$];
      int                     errors;

      function new();
         cfg              = '0;
         cfg.period_ticks = PERIOD_RESET;
         errors           = 0;
         reload();
      endfunction

      function void reload();
         current_q = cfg.initial_current;
         voltage_q = cfg.initial_voltage;
         phase_q   = '0;
      endfunction

      function void write_reg(bcs_csr_type idx, logic [CSR_DATA_WIDTH-1:0] data);
         case (idx)
            CSR_VIN:             cfg.vin             = data[VIN_WIDTH-1:0];
            CSR_STEP_PER_L:      cfg.step_per_l      = data[COEF_WIDTH-1:0];
            CSR_STEP_PER_C:      cfg.step_per_c      = data[COEF_WIDTH-1:0];
            CSR_STEP_PER_RC:     cfg.step_per_rc     = data[COEF_WIDTH-1:0];
            CSR_PERIOD_TICKS:    cfg.period_ticks    = data[TICK_WIDTH-1:0];
            CSR_ON_TICKS:        cfg.on_ticks        = data[TICK_WIDTH-1:0];
            CSR_INITIAL_CURRENT: cfg.initial_current = data[INIT_WIDTH-1:0];
            CSR_INITIAL_VOLTAGE: cfg.initial_voltage = data[INIT_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // Exact Q15.16 x Q8.24 product, truncated back to Q15.16
      function logic [63:0] scale(logic [63:0] value, logic [COEF_WIDTH-1:0] coef);
         logic [63:0] wide_coef;
         wide_coef = {32'd0, coef};
         return (value * wide_coef) >> COEF_FRAC;
      endfunction

      function logic [63:0] ceiling(logic [63:0] x);
         logic [63:0] top;
         top = (64'd1 << STATE_WIDTH) - 64'd1;
         return (x > top) ? top : x;
      endfunction

      // Advance the model by one time step and queue the response it gives
      function void take_step(logic restart);
         logic [63:0]            i0;
         logic [63:0]            v0;
         logic [63:0]            supply;
         logic [63:0]            loss;
         logic [63:0]            drop;
         logic [63:0]            sum;
         logic [63:0]            ni;
         logic [63:0]            nv;
         logic [PHASE_WIDTH-1:0] next_phase;
         logic                   on;
         bcs_result_type         r;
         if (restart) reload();
         i0     = {33'd0, current_q};
         v0     = {33'd0, voltage_q};
         supply = {33'd0, cfg.vin};
         on     = phase_q < cfg.on_ticks;
         loss   = scale(v0, cfg.step_per_rc);
         if (on) begin
            ni = ceiling(i0 + scale(supply, cfg.step_per_l));
            nv = (v0 >= loss) ? v0 - loss : 64'd0;
         end else begin
            if (supply >= v0) begin
               ni = ceiling(i0 + scale(supply - v0, cfg.step_per_l));
            end else begin
               drop = scale(v0 - supply, cfg.step_per_l);
               ni   = (i0 >= drop) ? i0 - drop : 64'd0;
            end
            sum = v0 + scale(i0, cfg.step_per_c);
            nv  = (sum >= loss) ? ceiling(sum - loss) : 64'd0;
         end
         current_q  = ni[STATE_WIDTH-1:0];
         voltage_q  = nv[STATE_WIDTH-1:0];
         next_phase = phase_q + 1'b1;
         if (next_phase >= cfg.period_ticks) next_phase = '0;
         phase_q = next_phase;
         r.inductor_current  = current_q[OUT_WIDTH-1:0];
         r.capacitor_voltage = voltage_q[OUT_WIDTH-1:0];
         r.switch_on         = on;
         expected_states.push_back(r);
      endfunction

      function void compare_state(logic [OUT_WIDTH-1:0] ic, logic [OUT_WIDTH-1:0] cv,
                                  logic sw);
         bcs_result_type e;
         if (expected_states.size() == 0) begin
            $error("response transfer with no step outstanding");
            errors++;
            return;
         end
         e = expected_states.pop_front();
         if (ic !== e.inductor_current) begin
            $error("inductor_current: expected %h, actual %h", e.inductor_current, ic);
            errors++;
         end
         if (cv !== e.capacitor_voltage) begin
            $error("capacitor_voltage: expected %h, actual %h", e.capacitor_voltage, cv);
            errors++;
         end
         if (sw !== e.switch_on) begin
            $error("switch_on: expected %b, actual %b", e.switch_on, sw);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_states.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels and the block
   // -------------------------------------------------------------------------
   logic                       clock;
   logic                       reset;
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata;
   bit                         calm;
   int                         cycle_count;

   converter_tracker tracker;

   bcs_req_if req_if();
   bcs_rsp_if rsp_if();

   boost_converter_step_model i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Stop a hung run; the limit leaves a wide margin over the slowest legal run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Drive helpers
   // -------------------------------------------------------------------------

   // Draw a random wait, or none while a calm stretch runs
   function automatic int draw_wait();
      if (calm) return 0;
      return $urandom_range(0, 9);
   endfunction

   // Hold the write enable high across back-to-back writes; finish_writes drops it
   task automatic csr_write(bcs_csr_type idx, logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      tracker.write_reg(idx, data);
   endtask

   task automatic finish_writes();
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Offer one step request after a random gap and note it once it transfers
   task automatic send_step(logic restart);
      int gap;
      gap = draw_wait();
      @(negedge clock);
      if (gap != 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.restart <= restart;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      tracker.take_step(restart);
   endtask

   // Drop valid and wait until every predicted response has arrived, then
   // let the pipeline run dry before any register changes
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Register value pickers: extremes, full random words and plausible values
   function automatic logic [31:0] pick_level();
      case ($urandom_range(0, 5))
         0:       return 32'd0;
         1:       return 32'h7FFF_FFFF;
         2:       return $urandom();
         default: return $urandom_range(0, 32'd60 << 16);
      endcase
   endfunction

   function automatic logic [31:0] pick_coef();
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom();
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   function automatic logic [31:0] pick_period();
      case ($urandom_range(0, 9))
         0:       return 32'd0;
         1:       return 32'd1;
         2:       return 32'h0000_FFFF;
         3:       return $urandom();
         default: return $urandom_range(2, 40);
      endcase
   endfunction

   function automatic logic [31:0] pick_on(logic [TICK_WIDTH-1:0] period);
      case ($urandom_range(0, 7))
         0:       return 32'd0;
         1:       return {16'd0, period};
         2:       return 32'h0000_FFFF;
         3:       return $urandom();
         default: return $urandom_range(0, period);
      endcase
   endfunction

   // Rewrite a random subset of the registers for the next random phase
   task automatic shuffle_setting();
      if ($urandom_range(0, 9) < 7) csr_write(CSR_VIN, pick_level());
      if ($urandom_range(0, 9) < 7) csr_write(CSR_STEP_PER_L, pick_coef());
      if ($urandom_range(0, 9) < 7) csr_write(CSR_STEP_PER_C, pick_coef());
      if ($urandom_range(0, 9) < 7) csr_write(CSR_STEP_PER_RC, pick_coef());
      if ($urandom_range(0, 9) < 8) csr_write(CSR_PERIOD_TICKS, pick_period());
      if ($urandom_range(0, 9) < 8) csr_write(CSR_ON_TICKS, pick_on(tracker.cfg.period_ticks));
      if ($urandom_range(0, 9) < 6) csr_write(CSR_INITIAL_CURRENT, pick_level());
      if ($urandom_range(0, 9) < 6) csr_write(CSR_INITIAL_VOLTAGE, pick_level());
      finish_writes();
   endtask

   // -------------------------------------------------------------------------
   // Response side: random stalls, check every transfer
   // -------------------------------------------------------------------------
   initial begin
      int stall;
      wait (reset == 1'b0);
      forever begin
         stall = draw_wait();
         @(negedge clock);
         if (stall != 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         tracker.compare_state(rsp_if.inductor_current, rsp_if.capacitor_voltage,
                               rsp_if.switch_on);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int  steps_left;
      int  run_len;
      logic restart_bit;

      tracker        = new();
      cycle_count    = 0;
      calm           = 1'b0;
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.restart = 1'b0;
      rsp_if.ready   = 1'b0;

      // Hold reset high, then release it at a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Register defaults: zero state, switch held off; restart reloads zeros
      send_step(1'b0);
      send_step(1'b1);
      settle();

      // Full supply and coefficients: current saturates while on, voltage
      // saturates once the switch opens; the top bit of vin must be dropped
      csr_write(CSR_VIN, 32'hFFFF_FFFF);
      csr_write(CSR_STEP_PER_L, 32'hFFFF_FFFF);
      csr_write(CSR_STEP_PER_C, 32'hFFFF_FFFF);
      csr_write(CSR_STEP_PER_RC, 32'h0000_0000);
      csr_write(CSR_PERIOD_TICKS, 32'd4);
      csr_write(CSR_ON_TICKS, 32'd2);
      csr_write(CSR_INITIAL_CURRENT, 32'h7FFF_FFFF);
      csr_write(CSR_INITIAL_VOLTAGE, 32'h0000_0000);
      finish_writes();
      send_step(1'b1);
      repeat (4) send_step(1'b0);
      settle();

      // Zero period, switch off, supply below the voltage: negative drive
      // clamps the current at zero and the load pulls the voltage to zero
      csr_write(CSR_VIN, 32'd0);
      csr_write(CSR_STEP_PER_C, 32'd0);
      csr_write(CSR_STEP_PER_RC, 32'hFFFF_FFFF);
      csr_write(CSR_PERIOD_TICKS, 32'd0);
      csr_write(CSR_ON_TICKS, 32'd0);
      csr_write(CSR_INITIAL_CURRENT, 32'h0000_1000);
      csr_write(CSR_INITIAL_VOLTAGE, 32'h7FFF_FFFF);
      finish_writes();
      send_step(1'b1);
      repeat (2) send_step(1'b0);
      settle();

      // On count above the period: switch stays on, voltage decays by half
      csr_write(CSR_VIN, 32'd12 << 16);
      csr_write(CSR_STEP_PER_L, 32'h0001_0000);
      csr_write(CSR_STEP_PER_RC, 32'h0080_0000);
      csr_write(CSR_PERIOD_TICKS, 32'd3);
      csr_write(CSR_ON_TICKS, 32'd5);
      csr_write(CSR_INITIAL_VOLTAGE, 32'h1234_5678);
      finish_writes();
      send_step(1'b1);
      repeat (2) send_step(1'b0);
      settle();

      // Walk the phase up to six, then lower the period beneath it
      csr_write(CSR_STEP_PER_C, 32'h0002_0000);
      csr_write(CSR_STEP_PER_RC, 32'h0001_0000);
      csr_write(CSR_PERIOD_TICKS, 32'd8);
      csr_write(CSR_ON_TICKS, 32'd3);
      csr_write(CSR_INITIAL_CURRENT, 32'd2 << 16);
      csr_write(CSR_INITIAL_VOLTAGE, 32'd5 << 16);
      finish_writes();
      send_step(1'b1);
      repeat (5) send_step(1'b0);
      settle();
      csr_write(CSR_PERIOD_TICKS, 32'd4);
      finish_writes();
      repeat (2) send_step(1'b0);

      // Random phases: new setting, optional restart, occasional full drain
      steps_left = RANDOM_STEPS;
      while (steps_left > 0) begin
         settle();
         shuffle_setting();
         calm    = ($urandom_range(0, 3) == 0);
         run_len = $urandom_range(40, 200);
         if (run_len > steps_left) run_len = steps_left;
         for (int k = 0; k < run_len; k++) begin
            if (k == 0) restart_bit = 1'($urandom_range(0, 1));
            else restart_bit = ($urandom_range(0, 31) == 0);
            if ($urandom_range(0, 149) == 0) settle();
            send_step(restart_bit);
         end
         steps_left -= run_len;
      end

      // Drain the last responses and allow a few more cycles for strays
      calm = 1'b0;
      settle();
      repeat (5) @(posedge clock);

      if (tracker.errors == 0 && tracker.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
